// File: hw/rtl/skf_pkg.sv
// Shared constants, control word types and microcode table for the scalar Kalman filter.
package skf_pkg;

  // Default datapath sizes.
  localparam int SAMPLE_BITS    = 16;
  localparam int GAIN_FRAC_BITS = 16;

  // Configuration port.
  localparam int CFG_WIDTH     = 16;
  localparam int CFG_IDX_WIDTH = 2;

  localparam logic [CFG_IDX_WIDTH-1:0] REG_INIT_EST  = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_INIT_ERR  = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_MEAS_ERR  = 2'd2;

  localparam logic [CFG_WIDTH-1:0] INIT_EST_RESET = 16'd2500;
  localparam logic [CFG_WIDTH-1:0] INIT_ERR_RESET = 16'd100;
  localparam logic [CFG_WIDTH-1:0] MEAS_ERR_RESET = 16'd10;

  // Datapath operations.
  localparam int OP_WIDTH = 4;
  localparam logic [OP_WIDTH-1:0] OP_NOP       = 4'd0;
  localparam logic [OP_WIDTH-1:0] OP_WAIT      = 4'd1;
  localparam logic [OP_WIDTH-1:0] OP_DEN       = 4'd2;
  localparam logic [OP_WIDTH-1:0] OP_DIV0      = 4'd3;
  localparam logic [OP_WIDTH-1:0] OP_DIV_STEP  = 4'd4;
  localparam logic [OP_WIDTH-1:0] OP_SAT       = 4'd5;
  localparam logic [OP_WIDTH-1:0] OP_GAIN_ZERO = 4'd6;
  localparam logic [OP_WIDTH-1:0] OP_MUL_K     = 4'd7;
  localparam logic [OP_WIDTH-1:0] OP_UPD_EST   = 4'd8;
  localparam logic [OP_WIDTH-1:0] OP_MUL_ERR   = 4'd9;
  localparam logic [OP_WIDTH-1:0] OP_UPD_ERR   = 4'd10;

  // Sequencer branch conditions.
  localparam int COND_WIDTH = 3;
  localparam logic [COND_WIDTH-1:0] COND_NEXT     = 3'd0;
  localparam logic [COND_WIDTH-1:0] COND_ALWAYS   = 3'd1;
  localparam logic [COND_WIDTH-1:0] COND_START    = 3'd2;
  localparam logic [COND_WIDTH-1:0] COND_DEN_ZERO = 3'd3;
  localparam logic [COND_WIDTH-1:0] COND_LOOP     = 3'd4;
  localparam logic [COND_WIDTH-1:0] COND_OUT_FREE = 3'd5;

  // Program addresses.
  localparam int STEP_WIDTH = 4;
  localparam logic [STEP_WIDTH-1:0] STEP_WAIT      = 4'd0;
  localparam logic [STEP_WIDTH-1:0] STEP_DEN       = 4'd1;
  localparam logic [STEP_WIDTH-1:0] STEP_DIV0      = 4'd2;
  localparam logic [STEP_WIDTH-1:0] STEP_DIV_STEP  = 4'd3;
  localparam logic [STEP_WIDTH-1:0] STEP_SAT       = 4'd4;
  localparam logic [STEP_WIDTH-1:0] STEP_GAIN_ZERO = 4'd5;
  localparam logic [STEP_WIDTH-1:0] STEP_MUL_K     = 4'd6;
  localparam logic [STEP_WIDTH-1:0] STEP_UPD_EST   = 4'd7;
  localparam logic [STEP_WIDTH-1:0] STEP_MUL_ERR   = 4'd8;
  localparam logic [STEP_WIDTH-1:0] STEP_UPD_ERR   = 4'd9;

  typedef struct packed {
    logic [OP_WIDTH-1:0]   op;
    logic [COND_WIDTH-1:0] cond;
    logic [STEP_WIDTH-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic start;
    logic den_zero;
    logic loop_more;
    logic out_busy;
  } stat_t;

  function automatic ctrl_t ucode_rom(input logic [STEP_WIDTH-1:0] step);
    ctrl_t cw;
    case (step)
      STEP_WAIT:      cw = '{op: OP_WAIT,      cond: COND_START,    target: STEP_WAIT};
      STEP_DEN:       cw = '{op: OP_DEN,       cond: COND_DEN_ZERO, target: STEP_GAIN_ZERO};
      STEP_DIV0:      cw = '{op: OP_DIV0,      cond: COND_NEXT,     target: STEP_WAIT};
      STEP_DIV_STEP:  cw = '{op: OP_DIV_STEP,  cond: COND_LOOP,     target: STEP_DIV_STEP};
      STEP_SAT:       cw = '{op: OP_SAT,       cond: COND_ALWAYS,   target: STEP_MUL_K};
      STEP_GAIN_ZERO: cw = '{op: OP_GAIN_ZERO, cond: COND_NEXT,     target: STEP_WAIT};
      STEP_MUL_K:     cw = '{op: OP_MUL_K,     cond: COND_NEXT,     target: STEP_WAIT};
      STEP_UPD_EST:   cw = '{op: OP_UPD_EST,   cond: COND_NEXT,     target: STEP_WAIT};
      STEP_MUL_ERR:   cw = '{op: OP_MUL_ERR,   cond: COND_NEXT,     target: STEP_WAIT};
      STEP_UPD_ERR:   cw = '{op: OP_UPD_ERR,   cond: COND_OUT_FREE, target: STEP_WAIT};
      default:        cw = '{op: OP_NOP,       cond: COND_ALWAYS,   target: STEP_WAIT};
    endcase
    return cw;
  endfunction

endpackage

// File: hw/rtl/scalar_kalman_filter.sv
// Top level of the scalar Kalman filter: config registers, sequencer and datapath.
// Flow: a word is accepted in the wait step, then summed, divided, saturated and used
//   to update estimate and error (divide skipped, gain zero when both errors are zero).
//   The gain comes from a one-bit-per-cycle restoring divider; no new word is accepted
//   until the last one is handed off, and a waiting result stalls only the last step.
// Reset: asynchronous, active low; config registers return to 2500/100/10 and the
//   estimate and error reset to 2500/100 as well; sequencer returns to its wait step.
module scalar_kalman_filter #(
  parameter int SAMPLE_BITS    = skf_pkg::SAMPLE_BITS,
  parameter int GAIN_FRAC_BITS = skf_pkg::GAIN_FRAC_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [skf_pkg::CFG_IDX_WIDTH-1:0] cfg_idx_i,
  input  logic [skf_pkg::CFG_WIDTH-1:0]     cfg_data_i,
  // measurement word in
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [SAMPLE_BITS-1:0]            measurement_i,
  // result word out
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [SAMPLE_BITS-1:0]            estimate_o,
  output logic [SAMPLE_BITS-1:0]            est_error_out_o,
  output logic [GAIN_FRAC_BITS-1:0]         gain_o
);

  // Config registers. Any write to a listed register also reloads the
  // filter state from the (updated) initial values; other indexes are dropped.
  logic [skf_pkg::CFG_WIDTH-1:0] init_est_q, init_err_q, meas_err_q;
  logic [skf_pkg::CFG_WIDTH-1:0] init_est_d, init_err_d, meas_err_d;
  logic                          cfg_hit;
  logic                          cfg_load_q;

  always_comb begin
    init_est_d = init_est_q;
    init_err_d = init_err_q;
    meas_err_d = meas_err_q;
    cfg_hit    = 1'b0;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        skf_pkg::REG_INIT_EST: begin
          init_est_d = cfg_data_i;
          cfg_hit    = 1'b1;
        end
        skf_pkg::REG_INIT_ERR: begin
          init_err_d = cfg_data_i;
          cfg_hit    = 1'b1;
        end
        skf_pkg::REG_MEAS_ERR: begin
          meas_err_d = cfg_data_i;
          cfg_hit    = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_est_q <= skf_pkg::INIT_EST_RESET;
      init_err_q <= skf_pkg::INIT_ERR_RESET;
      meas_err_q <= skf_pkg::MEAS_ERR_RESET;
      cfg_load_q <= 1'b0;
    end else begin
      init_est_q <= init_est_d;
      init_err_q <= init_err_d;
      meas_err_q <= meas_err_d;
      // state reloads in the following cycle, from the registered values
      cfg_load_q <= cfg_hit;
    end
  end

  // Sequencer walks the microprogram: wait, sum, divide loop and saturate (or zero gain),
  // multiply/update estimate, multiply/update error and hand off the word.
  skf_pkg::ctrl_t ctrl;
  skf_pkg::stat_t stat;

  skf_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  skf_dp #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .stat_o          (stat),
    .cfg_load_i      (cfg_load_q),
    .init_est_i      (init_est_q),
    .init_err_i      (init_err_q),
    .meas_err_i      (meas_err_q),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .measurement_i   (measurement_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .estimate_o      (estimate_o),
    .est_error_out_o (est_error_out_o),
    .gain_o          (gain_o)
  );

endmodule

// File: hw/rtl/skf_seq.sv
// Microcode sequencer: step counter, control ROM and branch logic.
module skf_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  skf_pkg::stat_t stat_i,
  output skf_pkg::ctrl_t ctrl_o
);

  logic [skf_pkg::STEP_WIDTH-1:0] step_q, step_d, step_inc;
  skf_pkg::ctrl_t cw;

  assign cw       = skf_pkg::ucode_rom(step_q);
  assign step_inc = step_q + skf_pkg::STEP_WIDTH'(1);

  always_comb begin
    case (cw.cond)
      skf_pkg::COND_NEXT:     step_d = step_inc;
      skf_pkg::COND_ALWAYS:   step_d = cw.target;
      skf_pkg::COND_START:    step_d = stat_i.start ? step_inc : step_q;
      skf_pkg::COND_DEN_ZERO: step_d = stat_i.den_zero ? cw.target : step_inc;
      skf_pkg::COND_LOOP:     step_d = stat_i.loop_more ? cw.target : step_inc;
      skf_pkg::COND_OUT_FREE: step_d = stat_i.out_busy ? step_q : cw.target;
      default:                step_d = skf_pkg::STEP_WAIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= skf_pkg::STEP_WAIT;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o = cw;

endmodule

// File: hw/rtl/skf_dp.sv
// Datapath: filter state, restoring divider, shared multiplier and output register.
module skf_dp #(
  parameter int SAMPLE_BITS    = skf_pkg::SAMPLE_BITS,
  parameter int GAIN_FRAC_BITS = skf_pkg::GAIN_FRAC_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  skf_pkg::ctrl_t                ctrl_i,
  output skf_pkg::stat_t                stat_o,
  input  logic                          cfg_load_i,
  input  logic [skf_pkg::CFG_WIDTH-1:0] init_est_i,
  input  logic [skf_pkg::CFG_WIDTH-1:0] init_err_i,
  input  logic [skf_pkg::CFG_WIDTH-1:0] meas_err_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [SAMPLE_BITS-1:0]        measurement_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [SAMPLE_BITS-1:0]        estimate_o,
  output logic [SAMPLE_BITS-1:0]        est_error_out_o,
  output logic [GAIN_FRAC_BITS-1:0]     gain_o
);

  localparam int S  = SAMPLE_BITS;
  localparam int F  = GAIN_FRAC_BITS;
  localparam int DW = ((S > skf_pkg::CFG_WIDTH) ? S : skf_pkg::CFG_WIDTH) + 1;
  localparam int CW = $clog2(F + 1);
  localparam int PW = F + 1 + S;
  localparam logic [F:0] GAIN_ONE = {1'b1, {F{1'b0}}};
  localparam logic [S-1:0] EST_RST = S'(skf_pkg::INIT_EST_RESET);
  localparam logic [S-1:0] ERR_RST = S'(skf_pkg::INIT_ERR_RESET);

  logic [skf_pkg::OP_WIDTH-1:0] op;
  logic start, fire, out_busy;

  logic [S-1:0]  meas_q, est_q, err_q;
  logic [DW-1:0] den_q, rem_q;
  logic [F:0]    quo_q;
  logic [CW-1:0] cnt_q;
  logic [F-1:0]  k_q;
  logic [PW-1:0] prod_q;
  logic          out_valid_q;
  logic [S-1:0]  out_est_q, out_err_q;
  logic [F-1:0]  out_gain_q;

  logic [DW-1:0] den_sum, init_rem;
  logic          init_ge, div_ge;
  logic [DW:0]   rem_sh, rem_sub;
  logic          neg;
  logic [S-1:0]  mag, step_up, step_dn, est_new, err_new;
  logic [F:0]    mul_a;
  logic [S-1:0]  mul_b;
  logic [PW-1:0] prod_d;
  logic [PW:0]   ceil_sum;

  assign op         = ctrl_i.op;
  assign in_ready_o = (op == skf_pkg::OP_WAIT);
  assign start      = in_valid_i & in_ready_o;
  assign out_busy   = out_valid_q & ~out_ready_i;
  assign fire       = (op == skf_pkg::OP_UPD_ERR) & ~out_busy;

  // divider: first quotient bit set only when err equals den (meas_error zero)
  assign den_sum  = DW'(err_q) + DW'(meas_err_i);
  assign init_ge  = DW'(err_q) >= den_q;
  assign init_rem = init_ge ? DW'(err_q) - den_q : DW'(err_q);
  assign rem_sh   = {rem_q, 1'b0};
  assign div_ge   = rem_sh >= {1'b0, den_q};
  assign rem_sub  = rem_sh - {1'b0, den_q};

  // shared multiplier
  assign neg    = meas_q < est_q;
  assign mag    = neg ? est_q - meas_q : meas_q - est_q;
  assign mul_a  = (op == skf_pkg::OP_MUL_ERR) ? GAIN_ONE - {1'b0, k_q} : {1'b0, k_q};
  assign mul_b  = (op == skf_pkg::OP_MUL_ERR) ? err_q : mag;
  assign prod_d = PW'(mul_a) * PW'(mul_b);

  // upward step truncates, downward step rounds up (floor of the signed product)
  assign step_up  = prod_q[F +: S];
  assign ceil_sum = (PW + 1)'(prod_q) + (PW + 1)'(GAIN_ONE - (F + 1)'(1));
  assign step_dn  = ceil_sum[F +: S];
  assign est_new  = neg ? est_q - step_dn : est_q + step_up;
  assign err_new  = prod_q[F +: S];

  assign stat_o = '{start:     start,
                    den_zero:  (den_sum == '0),
                    loop_more: (cnt_q != CW'(1)),
                    out_busy:  out_busy};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      est_q       <= EST_RST;
      err_q       <= ERR_RST;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_load_i) begin
        est_q <= S'(init_est_i);
        err_q <= S'(init_err_i);
      end else if (op == skf_pkg::OP_UPD_EST) begin
        est_q <= est_new;
      end else if (fire) begin
        err_q <= err_new;
      end
      if (op == skf_pkg::OP_DIV0) begin
        cnt_q <= CW'(F);
      end else if (op == skf_pkg::OP_DIV_STEP) begin
        cnt_q <= cnt_q - CW'(1);
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (op)
      skf_pkg::OP_WAIT: begin
        if (start) meas_q <= measurement_i;
      end
      skf_pkg::OP_DEN: begin
        den_q <= den_sum;
      end
      skf_pkg::OP_DIV0: begin
        quo_q <= {{F{1'b0}}, init_ge};
        rem_q <= init_rem;
      end
      skf_pkg::OP_DIV_STEP: begin
        quo_q <= {quo_q[F-1:0], div_ge};
        rem_q <= div_ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
      end
      skf_pkg::OP_SAT: begin
        k_q <= quo_q[F] ? {F{1'b1}} : quo_q[F-1:0];
      end
      skf_pkg::OP_GAIN_ZERO: begin
        k_q <= '0;
      end
      skf_pkg::OP_MUL_K, skf_pkg::OP_MUL_ERR: begin
        prod_q <= prod_d;
      end
      skf_pkg::OP_UPD_ERR: begin
        if (fire) begin
          out_est_q  <= est_q;
          out_err_q  <= err_new;
          out_gain_q <= k_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o     = out_valid_q;
  assign estimate_o      = out_est_q;
  assign est_error_out_o = out_err_q;
  assign gain_o          = out_gain_q;

  a_est_between: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op == skf_pkg::OP_UPD_EST) |->
      (neg ? (est_new <= est_q && est_new >= meas_q)
           : (est_new >= est_q && est_new <= meas_q)))
    else $error("estimate update left the old-estimate/measurement interval");

  a_err_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |-> (err_new <= err_q))
    else $error("estimate error grew");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op == skf_pkg::OP_DIV_STEP) |-> (cnt_q != '0))
    else $error("divider step with exhausted count");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> (out_valid_q && out_gain_q == $past(k_q)))
    else $error("result word not loaded with the gain in use");

endmodule

// File: tb/sv/kalman_checker.sv
// Scoreboard for the scalar Kalman filter: tracks config, predicts each result word, compares.
module kalman_checker
  import skf_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_WIDTH-1:0]  cfg_idx_i,
  input  logic [CFG_WIDTH-1:0]      cfg_data_i,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic [SAMPLE_BITS-1:0]    measurement_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic [SAMPLE_BITS-1:0]    estimate_i,
  input  logic [SAMPLE_BITS-1:0]    est_error_out_i,
  input  logic [GAIN_FRAC_BITS-1:0] gain_i,
  output int                        fail_count_o,
  output int                        outstanding_o
);

  localparam logic [63:0] GAIN_ONE = 64'd1 << GAIN_FRAC_BITS;
  localparam logic [63:0] GAIN_MAX = GAIN_ONE - 64'd1;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0]    est;
    logic [SAMPLE_BITS-1:0]    err;
    logic [GAIN_FRAC_BITS-1:0] gain;
  } update_t;

  logic [CFG_WIDTH-1:0]   init_est_q;
  logic [CFG_WIDTH-1:0]   init_err_q;
  logic [CFG_WIDTH-1:0]   meas_err_q;
  logic [SAMPLE_BITS-1:0] est_q;
  logic [SAMPLE_BITS-1:0] err_q;
  update_t                pending_updates[$];
  update_t                want;
  update_t                got;
  logic                   reload;

  // One filter step: gain, estimate move (floor), error scaling (truncated).
  function automatic update_t predict_update(input logic [SAMPLE_BITS-1:0] est,
                                             input logic [SAMPLE_BITS-1:0] err,
                                             input logic [CFG_WIDTH-1:0]   merr,
                                             input logic [SAMPLE_BITS-1:0] sample);
    logic [63:0] den;
    logic [63:0] k;
    logic [63:0] prod;
    update_t     r;
    den = 64'(err) + 64'(merr);
    if (den == 64'd0) begin
      k = 64'd0;
    end else begin
      k = (64'(err) << GAIN_FRAC_BITS) / den;
      if (k > GAIN_MAX) k = GAIN_MAX;   // merr of zero: exact gain of one saturates
    end
    if (sample >= est) begin
      prod  = k * 64'(sample - est);
      r.est = est + SAMPLE_BITS'(prod >> GAIN_FRAC_BITS);
    end else begin
      prod  = k * 64'(est - sample) + GAIN_MAX;
      r.est = est - SAMPLE_BITS'(prod >> GAIN_FRAC_BITS);
    end
    r.err  = SAMPLE_BITS'((64'(err) * (GAIN_ONE - k)) >> GAIN_FRAC_BITS);
    r.gain = GAIN_FRAC_BITS'(k);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_est_q    = INIT_EST_RESET;
      init_err_q    = INIT_ERR_RESET;
      meas_err_q    = MEAS_ERR_RESET;
      est_q         = SAMPLE_BITS'(INIT_EST_RESET);
      err_q         = SAMPLE_BITS'(INIT_ERR_RESET);
      pending_updates.delete();
      fail_count_o  = 0;
      outstanding_o = 0;
    end else begin
      // a word never leaves in the cycle it entered, so retire before predicting
      if (out_valid_i && out_ready_i) begin
        got = '{est: estimate_i, err: est_error_out_i, gain: gain_i};
        if (pending_updates.size() == 0) begin
          $error("unexpected result word: estimate %0d est_error_out %0d gain %0d",
                 got.est, got.err, got.gain);
          fail_count_o++;
        end else begin
          want = pending_updates.pop_front();
          if (got.est !== want.est) begin
            $error("estimate mismatch: expected %0d, actual %0d", want.est, got.est);
            fail_count_o++;
          end
          if (got.err !== want.err) begin
            $error("est_error_out mismatch: expected %0d, actual %0d", want.err, got.err);
            fail_count_o++;
          end
          if (got.gain !== want.gain) begin
            $error("gain mismatch: expected %0d, actual %0d", want.gain, got.gain);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        want = predict_update(est_q, err_q, meas_err_q, measurement_i);
        pending_updates.push_back(want);
        est_q = want.est;
        err_q = want.err;
      end
      if (cfg_we_i) begin
        reload = 1'b1;
        case (cfg_idx_i)
          REG_INIT_EST: init_est_q = cfg_data_i;
          REG_INIT_ERR: init_err_q = cfg_data_i;
          REG_MEAS_ERR: meas_err_q = cfg_data_i;
          default:      reload = 1'b0;   // unmapped index: no store, no reload
        endcase
        if (reload) begin
          est_q = SAMPLE_BITS'(init_est_q);
          err_q = SAMPLE_BITS'(init_err_q);
        end
      end
      outstanding_o = pending_updates.size();
    end
  end

endmodule

// File: tb/sv/tb.sv
// Testbench top: drives measurement words and register writes, gives the verdict.
module tb;
  import skf_pkg::*;

  // Index 3 is decoded by the port but maps to no register.
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SPARE = 2'd3;

  localparam int SAMPLE_MAX   = (1 << SAMPLE_BITS) - 1;
  localparam int RAND_ITEMS   = 1050;
  localparam int CYCLE_LIMIT  = 400000;  // timeout guard for the whole run
  localparam int HOLD_CYCLES  = 300;     // long receiver hold-off
  localparam int DRAIN_CYCLES = 30;      // settle time after the drain, before the final check

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   cfg_we      = 1'b0;
  logic [CFG_IDX_WIDTH-1:0] cfg_idx   = REG_INIT_EST;
  logic [CFG_WIDTH-1:0]   cfg_data    = '0;
  logic                   in_valid    = 1'b0;
  logic                   in_ready;
  logic [SAMPLE_BITS-1:0] measurement = '0;
  logic                   out_valid;
  logic                   out_ready   = 1'b0;
  logic [SAMPLE_BITS-1:0] estimate;
  logic [SAMPLE_BITS-1:0] est_error_out;
  logic [GAIN_FRAC_BITS-1:0] gain;

  int   fail_count;
  int   outstanding;
  int   samples_sent   = 0;
  int   settings_count = 0;
  int   stall_asks     = 0;   // bumped by stimulus
  int   stalls_done    = 0;   // bumped by the receiver once a hold-off is over
  int   cycle_count    = 0;
  logic calm           = 1'b0; // no random idling on either side while set

  logic [SAMPLE_BITS-1:0] base_est = SAMPLE_BITS'(INIT_EST_RESET);

  scalar_kalman_filter dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .measurement_i   (measurement),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .estimate_o      (estimate),
    .est_error_out_o (est_error_out),
    .gain_o          (gain)
  );

  kalman_checker u_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .measurement_i   (measurement),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .estimate_i      (estimate),
    .est_error_out_i (est_error_out),
    .gain_i          (gain),
    .fail_count_o    (fail_count),
    .outstanding_o   (outstanding)
  );

  // 4-unit clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Hard stop if the handshakes ever hang.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $error("timeout after %0d cycles, %0d result words still due", cycle_count, outstanding);
    $display("TB_ERROR");
    $finish;
  end

  // Result side. Ready is redecided every falling edge; about 8% of cycles are
  // stalls, except in the calm stretch. A stall request from stimulus drops
  // ready for a long hold-off so the filter backs up into its input.
  initial begin
    forever begin
      @(negedge clk);
      if (stall_asks != stalls_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        stalls_done++;
        out_ready <= 1'b1;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= 8);
      end
    end
  end

  // Offer one measurement word. Called at a falling edge; returns at the falling
  // edge after the word was taken, with valid still high so a back-to-back word
  // never sees valid drop and rise in the same step.
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] value);
    if (!calm && $urandom_range(0, 99) < 8) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(negedge clk);
    end
    in_valid    <= 1'b1;
    measurement <= value;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    samples_sent++;
  endtask

  // Stop offering and wait until every predicted word has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // One write cycle; write enable is left high so writes can go back to back.
  task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
                           input logic [CFG_WIDTH-1:0]     data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk);
  endtask

  // Full reprogram while idle, registers in a rotated order.
  task automatic load_settings(input logic [CFG_WIDTH-1:0] est0,
                               input logic [CFG_WIDTH-1:0] err0,
                               input logic [CFG_WIDTH-1:0] merr);
    int order;
    drain();
    order = $urandom_range(0, 2);
    for (int i = 0; i < 3; i++) begin
      case ((order + i) % 3)
        0:       write_reg(REG_INIT_EST, est0);
        1:       write_reg(REG_INIT_ERR, err0);
        default: write_reg(REG_MEAS_ERR, merr);
      endcase
    end
    cfg_we   <= 1'b0;
    base_est = SAMPLE_BITS'(est0);
    settings_count++;
  endtask

  // Register value: extremes, small errors (fast convergence to zero) and full range.
  function automatic logic [CFG_WIDTH-1:0] pick_reg_value();
    logic [CFG_WIDTH-1:0] v;
    case ($urandom_range(0, 11))
      0:       v = '0;
      1:       v = '1;
      2, 3:    v = CFG_WIDTH'($urandom_range(1, 20));
      4:       v = CFG_WIDTH'($urandom_range(1, 1000));
      default: v = CFG_WIDTH'($urandom());
    endcase
    return v;
  endfunction

  // Measurement: half near the phase's starting estimate, the rest full range and rails.
  function automatic logic [SAMPLE_BITS-1:0] pick_sample(input logic [SAMPLE_BITS-1:0] center);
    int v;
    case ($urandom_range(0, 9))
      0:       v = 0;
      1:       v = SAMPLE_MAX;
      2, 3, 4: v = int'($urandom_range(0, SAMPLE_MAX));
      default: v = int'(center) + int'($urandom_range(0, 1024)) - 512;
    endcase
    if (v < 0) v = 0;
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    return SAMPLE_BITS'(v);
  endfunction

  initial begin
    int phase;
    int random_count;
    int burst;

    phase        = 0;
    random_count = 0;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // --- Directed part ---
    // Reset settings (2500/100/10): equal sample, both rails.
    send_sample(SAMPLE_BITS'(2500));
    send_sample('0);
    send_sample('1);

    // Write to the unmapped index: the filter must keep its state, not reload.
    drain();
    write_reg(REG_SPARE, CFG_WIDTH'(16'h1234));
    cfg_we <= 1'b0;
    send_sample(SAMPLE_BITS'(2600));

    // Estimate at zero, huge error, tiny measurement error: gain near one,
    // largest upward move.
    load_settings('0, '1, CFG_WIDTH'(1));
    send_sample('1);
    send_sample('1);

    // Everything at full scale: large downward move, floor rounding.
    load_settings('1, '1, '1);
    send_sample('0);
    send_sample('0);
    send_sample(SAMPLE_BITS'(16'h8000));

    // Zero measurement error: gain saturates, error collapses to zero, and the
    // next word then sees both errors zero (gain zero, state held).
    load_settings(CFG_WIDTH'(1000), CFG_WIDTH'(1000), '0);
    send_sample(SAMPLE_BITS'(5000));
    send_sample(SAMPLE_BITS'(3000));

    // Both errors zero straight from configuration.
    load_settings(CFG_WIDTH'(777), '0, '0);
    send_sample('0);
    send_sample('1);

    // Zero estimate error with the largest measurement error: gain zero.
    load_settings(CFG_WIDTH'(30000), '0, '1);
    send_sample(SAMPLE_BITS'(40000));

    // --- Random part: phases of fresh settings followed by a burst of samples ---
    while (random_count < RAND_ITEMS) begin
      calm <= (phase >= 8 && phase <= 11);
      load_settings(pick_reg_value(), pick_reg_value(), pick_reg_value());
      if ($urandom_range(0, 9) == 0) begin
        // one cycle with the write enable low before the unmapped write
        @(negedge clk);
        write_reg(REG_SPARE, CFG_WIDTH'($urandom()));
        cfg_we <= 1'b0;
      end
      burst = $urandom_range(10, 60);
      for (int n = 0; n < burst; n++) begin
        // long output hold-off while input keeps offering words
        if ((phase == 3 || phase == 14) && n == 5) stall_asks++;
        send_sample(pick_sample(base_est));
      end
      random_count += burst;
      phase++;
    end

    drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (outstanding != 0) $error("%0d result words never arrived", outstanding);

    $display("Run covered %0d measurement words over %0d register settings, %0d long hold-offs.",
             samples_sent, settings_count, stalls_done);
    $display("Included rail samples, zero and saturated gain, unmapped writes; %0d mismatches.",
             fail_count);
    if (fail_count == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: scalar_kalman_filter.f
hw/rtl/skf_pkg.sv
hw/rtl/skf_seq.sv
hw/rtl/skf_dp.sv
hw/rtl/scalar_kalman_filter.sv
tb/sv/kalman_checker.sv
tb/sv/tb.sv
